// ----- hdl/wds_pkg.sv -----
`default_nettype none

package wds_pkg;

  // Item field widths
  localparam int FUNC_W   = 2;
  localparam int WEIGHT_W = 16;
  localparam int FRAC_W   = 16;
  localparam int LB_W     = 16;
  localparam int SAMPLE_W = 17;

  // Cumulative sum width and saturation value
  localparam int SUM_W = 24;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // Weight bits in use, and the mask they give on the weight field
  localparam int WEIGHT_BITS = 16;
  localparam logic [WEIGHT_W-1:0] WEIGHT_MASK = (WEIGHT_BITS >= WEIGHT_W) ?
      {WEIGHT_W{1'b1}} : WEIGHT_W'((64'd1 << WEIGHT_BITS) - 64'd1);

  // Default table depth
  localparam int MAX_ENTRIES_DEF = 256;

  // Function codes
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DRAW   = 2'd2;

endpackage

`default_nettype wire

// ----- hdl/wds_if.sv -----
`default_nettype none

// Input item channel
interface wds_in_if;
  logic                             valid;
  logic                             ready;
  logic [wds_pkg::FUNC_W-1:0]       func;
  logic [wds_pkg::WEIGHT_W-1:0]     weight;
  logic [wds_pkg::FRAC_W-1:0]       random_fraction;

  modport source (output valid, func, weight, random_fraction, input ready);
  modport sink   (input valid, func, weight, random_fraction, output ready);
endinterface

// Result item channel
interface wds_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [wds_pkg::SAMPLE_W-1:0] sample_value;
  logic                               table_empty;

  modport source (output valid, sample_value, table_empty, input ready);
  modport sink   (input valid, sample_value, table_empty, output ready);
endinterface

// Configuration write channel (lower bound)
interface wds_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [wds_pkg::LB_W-1:0]     data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ----- hdl/wds_cdf_ram.sv -----
`default_nettype none

// Cumulative weight table: one write port, one registered read port
module wds_cdf_ram #(
  parameter int DEPTH = wds_pkg::MAX_ENTRIES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                      clk,
  input  wire logic                      wr_en,
  input  wire logic [AW-1:0]             wr_addr,
  input  wire logic [wds_pkg::SUM_W-1:0] wr_data,
  input  wire logic [AW-1:0]             rd_addr,
  output logic      [wds_pkg::SUM_W-1:0] rd_data
);

  logic [wds_pkg::SUM_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- hdl/wds_search_step.sv -----
`default_nettype none

// One bisection step: compare fraction with the entry at mid, narrow [lo, hi]
module wds_search_step #(
  parameter int IDX_W = 8
) (
  input  wire logic [IDX_W-1:0]            lo,
  input  wire logic [IDX_W-1:0]            hi,
  input  wire logic [IDX_W-1:0]            mid,
  input  wire logic [wds_pkg::FRAC_W-1:0]  frac,
  input  wire logic [wds_pkg::SUM_W-1:0]   entry,
  output logic      [IDX_W-1:0]            lo_nxt,
  output logic      [IDX_W-1:0]            hi_nxt,
  output logic      [IDX_W-1:0]            mid_nxt,
  output logic                             done
);

  logic             go_up;
  logic [IDX_W:0]   span_sum;

  // fraction above entry: target lies right of mid
  assign go_up = {{(wds_pkg::SUM_W-wds_pkg::FRAC_W){1'b0}}, frac} > entry;

  always_comb begin
    if (go_up) begin
      lo_nxt = mid + IDX_W'(1);
      hi_nxt = hi;
    end else begin
      lo_nxt = lo;
      hi_nxt = mid;
    end
    span_sum = {1'b0, lo_nxt} + {1'b0, hi_nxt};
    mid_nxt  = span_sum[IDX_W:1];
    done     = (lo_nxt == hi_nxt);
  end

endmodule

`default_nettype wire

// ----- hdl/weighted_discrete_sampler.sv -----
`default_nettype none

// Channel  Dir  Payload                                  Handshake
// in_ch    in   func[1:0], weight[15:0], random_fraction  valid/ready
// out_ch   out  sample_value[16:0] signed, table_empty    valid/ready
// cfg_ch   in   data[15:0] = lower_bound (signed)        valid/ready
//
// Clear and append complete in the idle state; a draw for n loaded entries runs a bisection
// search (skipped for n <= 1), one table read and compare per step, then a finish step.
// The result sits in an output register; the next item is taken while it waits.
// A finished draw holds its result until the output register is free.
// Reset (rst_n low, synchronous) empties the table and clears lower_bound.
// Table contents are not cleared; only entries below the count are read.
module weighted_discrete_sampler #(
  parameter int MAX_ENTRIES = wds_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  wds_in_if.sink     in_ch,
  wds_out_if.source  out_ch,
  wds_cfg_if.sink    cfg_ch
);

  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_ENTRIES);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]                       state_r, state_nxt;
  logic [CNT_W-1:0]                 cnt_r, cnt_nxt;
  logic [wds_pkg::SUM_W-1:0]        sum_r, sum_nxt;
  logic [wds_pkg::LB_W-1:0]         lb_r;
  logic [IDX_W-1:0]                 lo_r, lo_nxt;
  logic [IDX_W-1:0]                 hi_r, hi_nxt;
  logic [IDX_W-1:0]                 mid_r, mid_nxt;
  logic [wds_pkg::FRAC_W-1:0]       frac_r, frac_nxt;
  logic                             empty_r, empty_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [wds_pkg::SAMPLE_W-1:0]     sample_r;
  logic                             out_empty_r;

  logic                             in_acc;
  logic                             out_free;
  logic                             load_out;
  logic [wds_pkg::SUM_W:0]          sum_wide;
  logic [wds_pkg::SUM_W-1:0]        sum_sat;
  logic                             wr_en;
  logic [IDX_W-1:0]                 rd_addr;
  logic [wds_pkg::SUM_W-1:0]        rd_data;
  logic [CNT_W-1:0]                 cnt_m1;
  logic [IDX_W-1:0]                 st_lo, st_hi, st_mid;
  logic                             st_done;
  logic [wds_pkg::SAMPLE_W-1:0]     sample_calc;

  // Handshake
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign load_out     = (state_r == ST_FINISH) && out_free;

  // Saturating running sum for append
  assign sum_wide = {1'b0, sum_r} +
      (wds_pkg::SUM_W + 1)'(in_ch.weight & wds_pkg::WEIGHT_MASK);
  assign sum_sat  = sum_wide[wds_pkg::SUM_W] ? wds_pkg::SUM_MAX
                                             : sum_wide[wds_pkg::SUM_W-1:0];

  assign wr_en  = in_acc && (in_ch.func == wds_pkg::FUNC_APPEND) && (cnt_r < CNT_FULL);
  assign cnt_m1 = cnt_r - CNT_W'(1);

  // Table read address: first probe when idle, next probe while searching
  assign rd_addr = (state_r == ST_SEARCH) ? st_mid : IDX_W'(cnt_m1 >> 1);

  wds_cdf_ram #(
    .DEPTH (MAX_ENTRIES),
    .AW    (IDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cnt_r[IDX_W-1:0]),
    .wr_data (sum_sat),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  wds_search_step #(
    .IDX_W (IDX_W)
  ) u_step (
    .lo      (lo_r),
    .hi      (hi_r),
    .mid     (mid_r),
    .frac    (frac_r),
    .entry   (rd_data),
    .lo_nxt  (st_lo),
    .hi_nxt  (st_hi),
    .mid_nxt (st_mid),
    .done    (st_done)
  );

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    frac_nxt      = frac_r;
    empty_nxt     = empty_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_ch.func)
            wds_pkg::FUNC_CLEAR: begin
              cnt_nxt = '0;
              sum_nxt = '0;
            end
            wds_pkg::FUNC_APPEND: begin
              if (cnt_r < CNT_FULL) begin
                cnt_nxt = cnt_r + CNT_W'(1);
                sum_nxt = sum_sat;
              end
            end
            wds_pkg::FUNC_DRAW: begin
              frac_nxt  = in_ch.random_fraction;
              lo_nxt    = '0;
              hi_nxt    = IDX_W'(cnt_m1);
              mid_nxt   = IDX_W'(cnt_m1 >> 1);
              empty_nxt = (cnt_r == '0);
              state_nxt = (cnt_r > CNT_W'(1)) ? ST_SEARCH : ST_FINISH;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SEARCH: begin
        lo_nxt  = st_lo;
        hi_nxt  = st_hi;
        mid_nxt = st_mid;
        if (st_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // lower_bound plus index, or zero for an empty table
  assign sample_calc = empty_r ? '0 :
      ({lb_r[wds_pkg::LB_W-1], lb_r} + wds_pkg::SAMPLE_W'(lo_r));

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      sum_r       <= '0;
      lb_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        lb_r <= cfg_ch.data;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    mid_r   <= mid_nxt;
    frac_r  <= frac_nxt;
    empty_r <= empty_nxt;
    if (load_out) begin
      sample_r    <= sample_calc;
      out_empty_r <= empty_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.sample_value = sample_r;
  assign out_ch.table_empty  = out_empty_r;

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("entry count above table depth");

  a_append_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("append did not advance entry count");

  a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH) |-> (lo_r <= mid_r) && (mid_r < hi_r) && (CNT_W'(hi_r) < cnt_r))
    else $error("search window out of order");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.table_empty) |-> (out_ch.sample_value == '0))
    else $error("empty draw with nonzero sample");

endmodule

`default_nettype wire
